// ----- sv/padz_pkg.sv -----
`timescale 1ns / 1ps
// Package for the angular dead-zone filter: constants, register codes,
// reset values and the CORDIC arctangent table. No dependencies.
package padz_pkg;

	localparam int TAG_W = 32;

	// configuration write channel
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ZEN_LOW  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZEN_HIGH = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AZ_LOW   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AZ_HIGH  = 4'd3;

	localparam int ZEN_W = 15;
	localparam int AZ_W  = 16;

	localparam logic [ZEN_W-1:0]        ZEN_LOW_RST  = 15'd4000;
	localparam logic [ZEN_W-1:0]        ZEN_HIGH_RST = 15'd7000;
	localparam logic signed [AZ_W-1:0]  AZ_LOW_RST   = -16'sd1000;
	localparam logic signed [AZ_W-1:0]  AZ_HIGH_RST  = 16'sd1000;

	// angle arithmetic: 1/256 centidegree per LSB
	localparam int AW          = 25;
	localparam int CDEG_SH     = 8;
	localparam int CDW         = AW - CDEG_SH;
	localparam int PRESCALE_SH = 16;
	localparam int CORDIC_GUARD = 2;
	localparam int TAB_LEN     = 24;

	localparam logic signed [AW-1:0] ANG_90   = 25'sd2304000;
	localparam logic signed [AW-1:0] ANG_HALF = 25'sd128;

	localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
		25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
		25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
		25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
		25'sd358,     25'sd179,    25'sd90,     25'sd45,
		25'sd22,      25'sd11,     25'sd6,      25'sd3,
		25'sd1,       25'sd1,      25'sd0,      25'sd0
	};

endpackage

// ----- sv/padz_ifs.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the dead-zone filter: point request, result request
// and configuration write. Depends on padz_pkg.
interface padz_point_if #(parameter int COORD_WIDTH = 20);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_mm;
	logic signed [COORD_WIDTH-1:0] y_mm;
	logic signed [COORD_WIDTH-1:0] z_mm;
	logic [padz_pkg::TAG_W-1:0]    point_tag;
	logic                          cloud_end;

	modport source (output valid, x_mm, y_mm, z_mm, point_tag, cloud_end, input ready);
	modport sink (input valid, x_mm, y_mm, z_mm, point_tag, cloud_end, output ready);
endinterface

interface padz_result_if;
	logic                       valid;
	logic                       ready;
	logic                       keep;
	logic [padz_pkg::TAG_W-1:0] tag_out;
	logic                       cloud_end_out;

	modport source (output valid, keep, tag_out, cloud_end_out, input ready);
	modport sink (input valid, keep, tag_out, cloud_end_out, output ready);
endinterface

interface padz_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [padz_pkg::CFG_IDX_W-1:0]  idx;
	logic [padz_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

// ----- sv/point_angular_dead_zone_filter.sv -----
`timescale 1ns / 1ps
// Pipeline from request to result: three front stages, one square-root stage per root
// bit, a quadrant stage and one CORDIC stage per rotation, then the output buffer.
// Throughput: one point per cycle; ready follows a two-entry output buffer and
// drops, stalling every stage, while that buffer is full.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module point_angular_dead_zone_filter #(
	parameter int COORD_WIDTH   = 20,
	parameter int CORDIC_STAGES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	padz_point_if.sink    point,
	padz_result_if.source result,
	padz_cfg_if.sink      cfg
);
	localparam int CW  = COORD_WIDTH;
	localparam int NW  = 2 * CW;
	localparam int TW  = padz_pkg::TAG_W;
	localparam int CDW = padz_pkg::CDW;
	localparam int SPW = 3 * CW + TW + 2;
	localparam int ZPW = TW + 1;

	typedef struct packed {
		logic          keep;
		logic [TW-1:0] tag;
		logic          ce;
	} res_ent_t;

	// configuration registers
	logic [padz_pkg::ZEN_W-1:0]       zl_q;
	logic [padz_pkg::ZEN_W-1:0]       zh_q;
	logic signed [padz_pkg::AZ_W-1:0] al_q;
	logic signed [padz_pkg::AZ_W-1:0] ah_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zl_q <= padz_pkg::ZEN_LOW_RST;
			zh_q <= padz_pkg::ZEN_HIGH_RST;
			al_q <= padz_pkg::AZ_LOW_RST;
			ah_q <= padz_pkg::AZ_HIGH_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.idx)
				padz_pkg::CFG_ZEN_LOW:  zl_q <= cfg.data[padz_pkg::ZEN_W-1:0];
				padz_pkg::CFG_ZEN_HIGH: zh_q <= cfg.data[padz_pkg::ZEN_W-1:0];
				padz_pkg::CFG_AZ_LOW:   al_q <= cfg.data;
				padz_pkg::CFG_AZ_HIGH:  ah_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline enable and output buffer state
	logic       en;
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	res_ent_t   ent_q [2];

	assign en          = (cnt_q != 2'd2);
	assign point.ready = en;

	// stage 1: capture request
	logic                 v_s1;
	logic signed [CW-1:0] x_s1, y_s1, z_s1;
	logic [TW-1:0]        tag_s1;
	logic                 ce_s1;

	// stage 2: squares
	logic                 v_s2;
	logic [NW-1:0]        xx_s2, yy_s2;
	logic signed [CW-1:0] x_s2, y_s2, z_s2;
	logic [TW-1:0]        tag_s2;
	logic                 ce_s2, org_s2;

	// stage 3: sum of squares
	logic                 v_s3;
	logic [NW-1:0]        sum_s3;
	logic signed [CW-1:0] x_s3, y_s3, z_s3;
	logic [TW-1:0]        tag_s3;
	logic                 ce_s3, org_s3;

	logic [CW-1:0] ax, ay;

	assign ax = x_s1[CW-1] ? (~x_s1 + 1'b1) : x_s1;
	assign ay = y_s1[CW-1] ? (~y_s1 + 1'b1) : y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= point.x_mm[CW-1:0];
			y_s1   <= point.y_mm[CW-1:0];
			z_s1   <= point.z_mm[CW-1:0];
			tag_s1 <= point.point_tag;
			ce_s1  <= point.cloud_end;

			xx_s2  <= NW'(ax) * NW'(ax);
			yy_s2  <= NW'(ay) * NW'(ay);
			org_s2 <= (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			tag_s2 <= tag_s1;
			ce_s2  <= ce_s1;

			sum_s3 <= xx_s2 + yy_s2;
			org_s3 <= org_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			tag_s3 <= tag_s2;
			ce_s3  <= ce_s2;
		end
	end

	// square root of x^2 + y^2
	logic                 sq_v;
	logic [CW-1:0]        sq_root;
	logic [SPW-1:0]       sq_pl;
	logic signed [CW-1:0] sq_x, sq_y, sq_z;
	logic [TW-1:0]        sq_tag;
	logic                 sq_ce, sq_org;

	padz_sqrt #(
		.CW (CW),
		.PW (SPW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s3),
		.n_in     (sum_s3),
		.pl_in    ({x_s3, y_s3, z_s3, tag_s3, ce_s3, org_s3}),
		.v_out    (sq_v),
		.root_out (sq_root),
		.pl_out   (sq_pl)
	);

	assign {sq_x, sq_y, sq_z, sq_tag, sq_ce, sq_org} = sq_pl;

	// zenith and azimuth, side by side
	logic                  zen_v, az_v;
	logic signed [CDW-1:0] zen_cd, az_cd;
	logic [ZPW-1:0]        zen_pl;
	logic                  az_org;

	padz_cordic #(
		.IW  (CW + 1),
		.NST (CORDIC_STAGES),
		.PW  (ZPW)
	) u_zen (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (sq_v),
		.a_in     ({sq_z[CW-1], sq_z}),
		.b_in     ({1'b0, sq_root}),
		.pl_in    ({sq_tag, sq_ce}),
		.v_out    (zen_v),
		.cdeg_out (zen_cd),
		.pl_out   (zen_pl)
	);

	padz_cordic #(
		.IW  (CW + 1),
		.NST (CORDIC_STAGES),
		.PW  (1)
	) u_az (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (sq_v),
		.a_in     ({sq_x[CW-1], sq_x}),
		.b_in     ({sq_y[CW-1], sq_y}),
		.pl_in    (sq_org),
		.v_out    (az_v),
		.cdeg_out (az_cd),
		.pl_out   (az_org)
	);

	// keep decision
	logic signed [CDW-1:0] zl_w, zh_w, al_w, ah_w;
	logic                  in_zone;
	logic                  push, pop;
	res_ent_t              ent_new;

	assign zl_w = {{(CDW-padz_pkg::ZEN_W){1'b0}}, zl_q};
	assign zh_w = {{(CDW-padz_pkg::ZEN_W){1'b0}}, zh_q};
	assign al_w = {{(CDW-padz_pkg::AZ_W){al_q[padz_pkg::AZ_W-1]}}, al_q};
	assign ah_w = {{(CDW-padz_pkg::AZ_W){ah_q[padz_pkg::AZ_W-1]}}, ah_q};

	assign in_zone = (zen_cd >= zl_w) && (zen_cd <= zh_w) && (az_cd > al_w) && (az_cd < ah_w);

	assign ent_new.keep = !(az_org || in_zone);
	assign ent_new.tag  = zen_pl[ZPW-1:1];
	assign ent_new.ce   = zen_pl[0];

	assign push = en && zen_v;
	assign pop  = result.valid && result.ready;

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= ent_new;
		end
	end

	assign result.valid         = (cnt_q != 2'd0);
	assign result.keep          = ent_q[rd_q].keep;
	assign result.tag_out       = ent_q[rd_q].tag;
	assign result.cloud_end_out = ent_q[rd_q].ce;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		zen_v == az_v)
		else $error("zenith and azimuth lanes out of step");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("output buffer overfilled");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(zen_v))
		else $error("pipeline moved during stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && cnt_q == 2'd1) |=> !result.valid)
		else $error("result shown after buffer drained");

endmodule

// ----- sv/padz_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with a side
// payload carried alongside. Standalone; stalls on a shared enable.
module padz_sqrt #(
	parameter int CW = 20,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  logic [2*CW-1:0] n_in,
	input  logic [PW-1:0]   pl_in,
	output logic            v_out,
	output logic [CW-1:0]   root_out,
	output logic [PW-1:0]   pl_out
);
	localparam int NW = 2 * CW;

	logic [NW-1:0] n_s  [CW];
	logic [NW-1:0] r_s  [CW];
	logic          v_s  [CW];
	logic [PW-1:0] pl_s [CW];

	for (genvar j = 0; j < CW; j++) begin : g_step
		localparam logic [NW-1:0] BIT = NW'(1) << (2 * (CW - 1 - j));
		logic [NW-1:0] n_i;
		logic [NW-1:0] r_i;
		logic [NW-1:0] t_i;
		logic          v_i;
		logic [PW-1:0] p_i;

		if (j == 0) begin : g_first
			assign n_i = n_in;
			assign r_i = '0;
			assign v_i = v_in;
			assign p_i = pl_in;
		end else begin : g_next
			assign n_i = n_s[j-1];
			assign r_i = r_s[j-1];
			assign v_i = v_s[j-1];
			assign p_i = pl_s[j-1];
		end

		assign t_i = r_i + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pl_s[j] <= p_i;
				if (n_i >= t_i) begin
					n_s[j] <= n_i - t_i;
					r_s[j] <= (r_i >> 1) + BIT;
				end else begin
					n_s[j] <= n_i;
					r_s[j] <= r_i >> 1;
				end
			end
		end
	end

	assign v_out    = v_s[CW-1];
	assign root_out = r_s[CW-1][CW-1:0];
	assign pl_out   = pl_s[CW-1];

endmodule

// ----- sv/padz_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC giving atan2(b, a) in centidegrees, one
// rotation per stage after a quadrant stage. Depends on padz_pkg.
module padz_cordic #(
	parameter int IW  = 21,
	parameter int NST = 16,
	parameter int PW  = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             v_in,
	input  logic signed [IW-1:0]             a_in,
	input  logic signed [IW-1:0]             b_in,
	input  logic [PW-1:0]                    pl_in,
	output logic                             v_out,
	output logic signed [padz_pkg::CDW-1:0]  cdeg_out,
	output logic [PW-1:0]                    pl_out
);
	localparam int PSH = padz_pkg::PRESCALE_SH;
	localparam int W   = IW + PSH + padz_pkg::CORDIC_GUARD;
	localparam int N   = (NST > padz_pkg::TAB_LEN) ? padz_pkg::TAB_LEN : NST;
	localparam int AW  = padz_pkg::AW;

	logic signed [W-1:0]  a_s   [N+1];
	logic signed [W-1:0]  b_s   [N+1];
	logic signed [AW-1:0] ang_s [N+1];
	logic                 v_s   [N+1];
	logic [PW-1:0]        pl_s  [N+1];

	logic signed [W-1:0]  a_w;
	logic signed [W-1:0]  b_w;
	logic signed [AW-1:0] ang_r;

	assign a_w = {{(W-IW-PSH){a_in[IW-1]}}, a_in, {PSH{1'b0}}};
	assign b_w = {{(W-IW-PSH){b_in[IW-1]}}, b_in, {PSH{1'b0}}};

	// quadrant stage: fold the left half plane onto the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s[0] <= pl_in;
			if (a_w[W-1]) begin
				if (!b_w[W-1]) begin
					a_s[0]   <= b_w;
					b_s[0]   <= -a_w;
					ang_s[0] <= padz_pkg::ANG_90;
				end else begin
					a_s[0]   <= -b_w;
					b_s[0]   <= a_w;
					ang_s[0] <= -padz_pkg::ANG_90;
				end
			end else begin
				a_s[0]   <= a_w;
				b_s[0]   <= b_w;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pl_s[i+1] <= pl_s[i];
				if (!b_s[i][W-1]) begin
					a_s[i+1]   <= a_s[i] + (b_s[i] >>> i);
					b_s[i+1]   <= b_s[i] - (a_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] + padz_pkg::ATAN_TAB[i];
				end else begin
					a_s[i+1]   <= a_s[i] - (b_s[i] >>> i);
					b_s[i+1]   <= b_s[i] + (a_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] - padz_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	// round to centidegrees
	assign ang_r    = ang_s[N] + padz_pkg::ANG_HALF;
	assign cdeg_out = ang_r[AW-1:padz_pkg::CDEG_SH];
	assign v_out    = v_s[N];
	assign pl_out   = pl_s[N];

endmodule
